/* design/mbw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_pkg
// Shared codes, box type tags and small helpers for the box walk validator.
// ----------------------------------------------------------------------------
package mbw_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] CFG_AUDIO_ONLY    = 2'd1;

    localparam int WINDOW_W = 36;
    localparam int CARVE_W  = 36;
    localparam int ATOM_W   = 17;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 36'h4_0000_0000;

    // top-level walk phases
    localparam logic [1:0] WALK_HEAD = 2'd0;
    localparam logic [1:0] WALK_EXT  = 2'd1;
    localparam logic [1:0] WALK_BODY = 2'd2;
    localparam logic [1:0] WALK_DONE = 2'd3;

    // moov child walk phases
    localparam logic [2:0] NEST_OFF    = 3'd0;
    localparam logic [2:0] NEST_HEAD   = 3'd1;
    localparam logic [2:0] NEST_SKIP   = 3'd2;
    localparam logic [2:0] NEST_HDLR   = 3'd3;
    localparam logic [2:0] NEST_BROKEN = 3'd4;

    // reject reasons
    localparam logic [1:0] REASON_NONE     = 2'd0;
    localparam logic [1:0] REASON_BAD_TYPE = 2'd1;
    localparam logic [1:0] REASON_NO_KEY   = 2'd2;
    localparam logic [1:0] REASON_VIDEO    = 2'd3;

    // four-character codes, first character in the top byte
    localparam logic [31:0] FOURCC_FTYP = 32'h6674_7970;
    localparam logic [31:0] FOURCC_MDAT = 32'h6D64_6174;
    localparam logic [31:0] FOURCC_MOOV = 32'h6D6F_6F76;
    localparam logic [31:0] FOURCC_TRAK = 32'h7472_616B;
    localparam logic [31:0] FOURCC_MDIA = 32'h6D64_6961;
    localparam logic [31:0] FOURCC_HDLR = 32'h6864_6C72;
    localparam logic [31:0] FOURCC_VIDE = 32'h7669_6465;

    localparam logic [7:0] CHAR_HIGH_MIN = 8'hA9;

    typedef struct packed {
        logic step;   // byte lands in a top-level box body
        logic kill;   // child walk ends (box left, result given, stream end)
        logic start;  // moov accepted in audio-only mode
    } nest_ctrl_t;

    typedef struct packed {
        logic              verdict;
        logic [1:0]        reject_reason;
        logic [CARVE_W-1:0] carve_length;
        logic [ATOM_W-1:0] atom_count;
    } result_t;

    function automatic logic char_ok(input logic [7:0] c);
        char_ok = (c == 8'h20) || (c == 8'h2D) ||
                  (c >= 8'h30 && c <= 8'h39) ||
                  (c >= 8'h41 && c <= 8'h5A) ||
                  (c >= 8'h61 && c <= 8'h7A) || (c >= CHAR_HIGH_MIN);
    endfunction

endpackage

/* design/mp4_box_walk_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_box_walk_validator
// Streaming validity check of a candidate ISO media container, one byte/item.
// ----------------------------------------------------------------------------
// The block takes one byte per item from offset zero of a candidate container
// and walks its top-level boxes (32-bit or 64-bit size, four-character type),
// checking type characters and that each box fits the configured window. One
// result item per stream: verdict, reject reason, carve length (end of the
// last counted box) and number of boxes counted. With audio_only_mode set the
// trak/mdia/hdlr children of moov are followed and a "vide" handler rejects
// the stream at once. Bytes after the result are dropped up to the byte
// flagged end_of_source, which also restarts the walk; registers are kept.
// Rate: one byte per cycle sustained while the output register is free or
// being drained. A byte sits in the input register while the walk logic
// updates its state, and a result item lands in the output register, from
// which it is offered; the input side keeps flowing while that register is
// free or being drained.
// Configuration writes are taken in any cycle and apply from the next byte.
// ----------------------------------------------------------------------------
module mp4_box_walk_validator import mbw_pkg::*; #(
    parameter int MAX_BOXES     = 100000,
    parameter int POSITION_BITS = 36
) (
    input  logic                aclk,
    input  logic                aresetn,
    // byte stream in
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_end_of_source,
    // result out
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_verdict,
    output logic [1:0]          m_reject_reason,
    output logic [CARVE_W-1:0]  m_carve_length,
    output logic [ATOM_W-1:0]   m_atom_count,
    // register writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_addr,
    input  logic [WINDOW_W-1:0] cfg_data
);

    // input stage
    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_eos_reg;
    // output stage
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg;
    // registers
    logic [WINDOW_W-1:0] window_reg;
    logic                audio_reg;

    logic                advance;
    logic                emit;
    result_t             result;

    // the walk step runs whenever a byte is held and the output slot can take a result
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    mbw_walk #(
        .MAX_BOXES     (MAX_BOXES),
        .POSITION_BITS (POSITION_BITS)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .data          (in_byte_reg),
        .eos           (in_eos_reg),
        .window_length (window_reg),
        .audio_only    (audio_reg),
        .emit          (emit),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= WINDOW_RESET;
            audio_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_addr == CFG_WINDOW_LENGTH) begin
                window_reg <= cfg_data;
            end
            if (cfg_valid && cfg_addr == CFG_AUDIO_ONLY) begin
                audio_reg <= cfg_data[0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eos_reg  <= s_end_of_source;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_verdict       = out_reg.verdict;
    assign m_reject_reason = out_reg.reject_reason;
    assign m_carve_length  = out_reg.carve_length;
    assign m_atom_count    = out_reg.atom_count;

endmodule

/* design/mbw_nest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_nest
// Walks trak / mdia / hdlr children of a moov body and flags a video handler.
// ----------------------------------------------------------------------------
module mbw_nest import mbw_pkg::*; #(
    parameter int POSITION_BITS = 36
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  nest_ctrl_t               ctrl,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [POSITION_BITS-1:0] moov_end,
    input  logic [7:0]               data,
    output logic                     video_found
);

    localparam int P  = POSITION_BITS;
    localparam int SW = (P > 32) ? P : 32;

    logic [2:0]   phase_reg, phase_next;
    logic [1:0]   level_reg, level_next;
    logic [2:0]   count_reg, count_next;
    logic [P-1:0] cstart_reg, cstart_next;
    logic [P-1:0] cend_reg, cend_next;
    logic [P-1:0] nend_reg [0:2];
    logic [7:0]   nhdr_reg [0:11];

    logic         nend_we;
    logic [1:0]   nend_idx;
    logic [P-1:0] nend_val;
    logic         nhdr_we;
    logic [3:0]   nhdr_idx;

    function automatic logic [P-1:0] end_at(input logic [1:0] lv,
                                            input logic [P-1:0] e0,
                                            input logic [P-1:0] e1,
                                            input logic [P-1:0] e2);
        case (lv)
            2'd0:    end_at = e0;
            2'd1:    end_at = e1;
            default: end_at = e2;
        endcase
    endfunction

    always_comb begin
        logic         gone;
        logic [P-1:0] lend;
        logic [P-1:0] room;
        logic [P-1:0] off;
        logic [31:0]  sz;
        logic [31:0]  ctype;
        phase_next  = phase_reg;
        level_next  = level_reg;
        count_next  = count_reg;
        cstart_next = cstart_reg;
        cend_next   = cend_reg;
        nend_we     = 1'b0;
        nend_idx    = 2'd0;
        nend_val    = moov_end;
        nhdr_we     = 1'b0;
        nhdr_idx    = {1'b0, count_reg};
        video_found = 1'b0;
        gone        = 1'b0;
        lend        = '0;
        room        = '0;
        off         = pos - cstart_reg;
        sz          = {nhdr_reg[0], nhdr_reg[1], nhdr_reg[2], nhdr_reg[3]};
        ctype       = {nhdr_reg[4], nhdr_reg[5], nhdr_reg[6], data};

        if (ctrl.step && phase_reg != NEST_OFF) begin
            // child finished: next child header starts here
            if ((phase_next == NEST_SKIP || phase_next == NEST_HDLR) &&
                pos >= cend_reg) begin
                phase_next  = NEST_HEAD;
                count_next  = 3'd0;
                cstart_next = pos;
            end
            // parent levels exhausted: climb out, at most three levels
            for (int i = 0; i < 3; i++) begin
                lend = end_at(level_next, nend_reg[0], nend_reg[1], nend_reg[2]);
                if (!gone && (phase_next == NEST_BROKEN ||
                    (phase_next == NEST_HEAD && count_next == 3'd0)) && pos >= lend) begin
                    if (level_next != 2'd0) begin
                        level_next  = level_next - 2'd1;
                        phase_next  = NEST_HEAD;
                        count_next  = 3'd0;
                        cstart_next = pos;
                    end else begin
                        phase_next = NEST_OFF;
                        gone       = 1'b1;
                    end
                end
            end
            lend = end_at(level_next, nend_reg[0], nend_reg[1], nend_reg[2]);
            if (!gone && phase_next == NEST_HEAD && count_next == 3'd0 &&
                (lend - pos) < P'(8)) begin
                phase_next = NEST_BROKEN;
            end

            if (!gone && phase_next == NEST_HEAD) begin
                nhdr_we    = 1'b1;
                nhdr_idx   = {1'b0, count_next};
                if (count_next == 3'd7) begin
                    room = lend - cstart_next;
                    if (sz < 32'd8 || SW'(sz) > SW'(room)) begin
                        phase_next = NEST_BROKEN;
                    end else begin
                        cend_next = cstart_next + P'(sz);
                        if ((level_next == 2'd0 && ctype == FOURCC_TRAK) ||
                            (level_next == 2'd1 && ctype == FOURCC_MDIA)) begin
                            level_next  = level_next + 2'd1;
                            nend_we     = 1'b1;
                            nend_idx    = level_next;
                            nend_val    = cend_next;
                            phase_next  = NEST_HEAD;
                            count_next  = 3'd0;
                            cstart_next = pos + P'(1);
                        end else if (level_next == 2'd2 && ctype == FOURCC_HDLR) begin
                            phase_next = NEST_HDLR;
                        end else begin
                            phase_next = NEST_SKIP;
                        end
                    end
                end else begin
                    count_next = count_next + 3'd1;
                end
            end else if (!gone && phase_next == NEST_HDLR) begin
                // handler type sits at offsets 16 to 19 of the hdlr box
                off = pos - cstart_next;
                if (off >= P'(16) && off <= P'(19)) begin
                    nhdr_we  = 1'b1;
                    nhdr_idx = 4'd8 + 4'(off - P'(16));
                    if (off == P'(19) &&
                        {nhdr_reg[8], nhdr_reg[9], nhdr_reg[10], data} == FOURCC_VIDE) begin
                        video_found = 1'b1;
                    end
                end
            end
        end

        if (ctrl.kill) begin
            phase_next = NEST_OFF;
        end else if (ctrl.start) begin
            phase_next  = NEST_HEAD;
            level_next  = 2'd0;
            count_next  = 3'd0;
            cstart_next = pos + P'(1);
            nend_we     = 1'b1;
            nend_idx    = 2'd0;
            nend_val    = moov_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= NEST_OFF;
            level_reg <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cstart_reg <= cstart_next;
        cend_reg   <= cend_next;
        if (nend_we) begin
            nend_reg[nend_idx] <= nend_val;
        end
        if (nhdr_we) begin
            nhdr_reg[nhdr_idx] <= data;
        end
    end

endmodule

/* design/mbw_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_walk
// Top-level box walk: header capture, size and window checks, verdict.
// ----------------------------------------------------------------------------
module mbw_walk import mbw_pkg::*; #(
    parameter int MAX_BOXES     = 100000,
    parameter int POSITION_BITS = 36
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data,
    input  logic                eos,
    input  logic [WINDOW_W-1:0] window_length,
    input  logic                audio_only,
    output logic                emit,
    output result_t             result
);

    localparam int P  = POSITION_BITS;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int WW = (P > WINDOW_W) ? P : WINDOW_W;
    localparam int AW = (CW > ATOM_W) ? CW : ATOM_W;

    logic [P-1:0]  pos_reg, pos_next;
    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [P-1:0]  start_reg, start_next;
    logic [P-1:0]  end_reg, end_next;
    logic [P-1:0]  last_reg, last_next;
    logic [CW-1:0] boxes_reg, boxes_next;
    logic          ftyp_reg, ftyp_next;
    logic          key_reg, key_next;
    logic [7:0]    hdr_reg [0:15];

    logic          hdr_we;
    logic [3:0]    hdr_idx;
    nest_ctrl_t    nctrl;
    logic          video;

    logic [WW-1:0] wl_w;
    logic [WW-1:0] mask_w;
    logic [P-1:0]  win;

    assign wl_w   = WW'(window_length);
    assign mask_w = WW'({P{1'b1}});
    assign win    = (wl_w < mask_w) ? wl_w[P-1:0] : {P{1'b1}};

    mbw_nest #(.POSITION_BITS(POSITION_BITS)) u_nest (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (nctrl),
        .pos         (pos_reg),
        .moov_end    (end_next),
        .data        (data),
        .video_found (video)
    );

    always_comb begin
        logic          exit_body;
        logic [1:0]    ph0;
        logic [3:0]    cnt0;
        logic          fin;
        logic          badchar;
        logic          is_ext;
        logic [31:0]   sz32;
        logic [31:0]   btype;
        logic [63:0]   size64;
        logic [63:0]   hlen;
        logic [P-1:0]  room;
        logic          chars;
        logic [WW-1:0] carve_w;
        logic [AW-1:0] atoms_w;

        exit_body = (phase_reg == WALK_BODY) && (pos_reg >= end_reg);
        ph0       = exit_body ? WALK_HEAD : phase_reg;
        cnt0      = exit_body ? 4'd0 : cnt_reg;
        fin       = 1'b0;
        badchar   = 1'b0;
        is_ext    = (ph0 == WALK_EXT);
        sz32      = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]};
        btype     = {hdr_reg[4], hdr_reg[5], hdr_reg[6], data};
        chars     = char_ok(hdr_reg[4]) && char_ok(hdr_reg[5]) &&
                    char_ok(hdr_reg[6]) && char_ok(data);
        size64    = is_ext ? {hdr_reg[8], hdr_reg[9], hdr_reg[10], hdr_reg[11],
                              hdr_reg[12], hdr_reg[13], hdr_reg[14], data}
                           : {32'd0, sz32};
        hlen      = is_ext ? 64'd16 : 64'd8;
        room      = win - start_reg;
        if (is_ext) begin
            btype = {hdr_reg[4], hdr_reg[5], hdr_reg[6], hdr_reg[7]};
        end

        phase_next = ph0;
        cnt_next   = cnt0;
        start_next = start_reg;
        end_next   = end_reg;
        last_next  = last_reg;
        boxes_next = boxes_reg;
        ftyp_next  = ftyp_reg;
        key_next   = key_reg;
        hdr_we     = 1'b0;
        hdr_idx    = cnt0;
        nctrl      = '0;
        emit       = 1'b0;
        result     = '0;
        pos_next   = pos_reg;

        if (step) begin
            if (phase_reg != WALK_DONE) begin
                if (ph0 == WALK_HEAD && cnt0 == 4'd0) begin
                    start_next = pos_reg;
                    room       = win - pos_reg;
                    if (({1'b0, pos_reg} + (P+1)'(8)) > {1'b0, win} ||
                        boxes_reg >= CW'(MAX_BOXES)) begin
                        fin = 1'b1;
                    end
                end
                if (!fin && (ph0 == WALK_HEAD || ph0 == WALK_EXT)) begin
                    hdr_we   = 1'b1;
                    cnt_next = cnt0 + 4'd1;
                    if ((ph0 == WALK_HEAD && cnt0 == 4'd7) ||
                        (ph0 == WALK_EXT && cnt0 == 4'd15)) begin
                        if (!is_ext && !chars) begin
                            badchar = 1'b1;
                        end else if (!is_ext && sz32 == 32'd0) begin
                            fin = 1'b1;
                        end else if (!is_ext && sz32 == 32'd1) begin
                            phase_next = WALK_EXT;
                        end else if (is_ext && size64[63]) begin
                            fin = 1'b1;
                        end else if (size64 < hlen || start_next > win ||
                                     size64 > 64'(room)) begin
                            fin = 1'b1;
                        end else begin
                            if (btype == FOURCC_FTYP) begin
                                ftyp_next = 1'b1;
                            end
                            if (btype == FOURCC_MDAT || btype == FOURCC_MOOV) begin
                                key_next = 1'b1;
                            end
                            end_next   = start_next + size64[P-1:0];
                            last_next  = end_next;
                            boxes_next = boxes_reg + CW'(1);
                            phase_next = WALK_BODY;
                            nctrl.start = audio_only && (btype == FOURCC_MOOV);
                        end
                    end
                end else if (ph0 == WALK_BODY) begin
                    nctrl.step = 1'b1;
                end
            end

            if (video) begin
                emit                 = 1'b1;
                result.verdict       = 1'b1;
                result.reject_reason = REASON_VIDEO;
            end else if (badchar) begin
                emit = 1'b1;
                if (boxes_reg == '0) begin
                    result.verdict       = 1'b1;
                    result.reject_reason = REASON_BAD_TYPE;
                end
            end else if (fin || (eos && phase_next != WALK_DONE &&
                                 phase_reg != WALK_DONE)) begin
                emit = 1'b1;
                if (boxes_next < CW'(2) || !(ftyp_next || key_next)) begin
                    result.verdict       = 1'b1;
                    result.reject_reason = REASON_NO_KEY;
                end
            end
            if (emit && !result.verdict) begin
                carve_w             = WW'(last_next);
                result.carve_length = carve_w[CARVE_W-1:0];
            end
            atoms_w           = AW'(boxes_next);
            result.atom_count = atoms_w[ATOM_W-1:0];
            if (emit) begin
                phase_next = WALK_DONE;
            end
            nctrl.kill = emit || eos || exit_body;
            pos_next   = pos_reg + P'(1);

            if (eos) begin
                pos_next   = '0;
                phase_next = WALK_HEAD;
                cnt_next   = 4'd0;
                start_next = '0;
                end_next   = '0;
                last_next  = '0;
                boxes_next = '0;
                ftyp_next  = 1'b0;
                key_next   = 1'b0;
            end
        end else begin
            phase_next = phase_reg;
            cnt_next   = cnt_reg;
            start_next = start_reg;
            end_next   = end_reg;
        end
        carve_w = '0;
        atoms_w = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= WALK_HEAD;
            cnt_reg   <= 4'd0;
            start_reg <= '0;
            end_reg   <= '0;
            last_reg  <= '0;
            boxes_reg <= '0;
            ftyp_reg  <= 1'b0;
            key_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            last_reg  <= last_next;
            boxes_reg <= boxes_next;
            ftyp_reg  <= ftyp_next;
            key_reg   <= key_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_reg[hdr_idx] <= data;
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MP4 box walk validator.
// ----------------------------------------------------------------------------
// Streams of bytes (well-formed containers with random content, broken
// headers and plain noise) are fed one item per byte. A behavioural copy of
// the box walk runs on every accepted item and queues the verdict it expects.
// Each result item is compared field by field with the oldest queued verdict.
// Both sides idle at random in several phases, and the receiver is held off
// for a long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
    import mbw_pkg::*;

    localparam longint unsigned POS_MASK  = 64'hF_FFFF_FFFF;
    localparam longint unsigned SIZE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int unsigned     BOX_LIMIT = 100000;
    localparam logic [31:0]     FOURCC_SOUN = 32'h736F_756E;
    localparam logic [31:0]     FOURCC_MDHD = 32'h6D64_6864;
    localparam logic [31:0]     FOURCC_FREE = 32'h6672_6565;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_data_byte;
    logic                s_end_of_source;
    logic                m_valid;
    logic                m_ready;
    logic                m_verdict;
    logic [1:0]          m_reject_reason;
    logic [CARVE_W-1:0]  m_carve_length;
    logic [ATOM_W-1:0]   m_atom_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_addr;
    logic [WINDOW_W-1:0] cfg_data;

    mp4_box_walk_validator uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_source (s_end_of_source),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_reject_reason (m_reject_reason),
        .m_carve_length  (m_carve_length),
        .m_atom_count    (m_atom_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioural box walk: registers, walk state and the verdict queue
    // ------------------------------------------------------------------
    longint unsigned win_len;
    bit              audio_mode;

    longint unsigned walk_pos, box_start, box_end, last_end;
    byte unsigned    box_hdr [16];
    int unsigned     hdr_cnt, box_count;
    bit              seen_ftyp, seen_key;
    logic [1:0]      walk_ph;
    longint unsigned child_lim [3];
    byte unsigned    child_hdr [12];
    logic [2:0]      child_ph;
    int unsigned     child_lvl, child_cnt;
    longint unsigned child_start, child_end;

    bit      verdict_due;
    result_t verdict_now;
    result_t verdicts_due [$];

    function automatic bit type_char_ok(byte unsigned c);
        return c inside {8'h20, 8'h2D, [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}
               || c >= 8'hA9;
    endfunction

    function automatic void restart_walk();
        walk_pos = 0; box_start = 0; box_end = 0; last_end = 0;
        hdr_cnt = 0; box_count = 0; seen_ftyp = 0; seen_key = 0;
        walk_ph = WALK_HEAD; child_ph = NEST_OFF; child_lvl = 0; child_cnt = 0;
        child_start = 0; child_end = 0;
        foreach (box_hdr[i]) box_hdr[i] = 0;
        foreach (child_hdr[i]) child_hdr[i] = 0;
        foreach (child_lim[i]) child_lim[i] = 0;
    endfunction

    function automatic void post_verdict(bit v, logic [1:0] why, longint unsigned carve);
        verdict_now.verdict       = v;
        verdict_now.reject_reason = why;
        verdict_now.carve_length  = carve[CARVE_W-1:0];
        verdict_now.atom_count    = box_count[ATOM_W-1:0];
        verdict_due = 1;
        walk_ph  = WALK_DONE;
        child_ph = NEST_OFF;
    endfunction

    function automatic void close_walk();
        if (box_count < 2 || !(seen_ftyp || seen_key))
            post_verdict(1'b1, REASON_NO_KEY, 0);
        else
            post_verdict(1'b0, REASON_NONE, last_end);
    endfunction

    function automatic longint unsigned window_limit();
        return (win_len < POS_MASK) ? win_len : POS_MASK;
    endfunction

    function automatic void take_box(longint unsigned pos, longint unsigned size,
                                     longint unsigned hlen);
        longint unsigned lim;
        logic [31:0]     tag;
        lim = window_limit();
        tag = {box_hdr[4], box_hdr[5], box_hdr[6], box_hdr[7]};
        if (size < hlen || box_start > lim || size > lim - box_start) begin
            close_walk();
            return;
        end
        if (tag == FOURCC_FTYP) seen_ftyp = 1;
        if (tag == FOURCC_MDAT || tag == FOURCC_MOOV) seen_key = 1;
        box_end  = box_start + size;
        last_end = box_end;
        box_count++;
        walk_ph  = WALK_BODY;
        child_ph = NEST_OFF;
        if (audio_mode && tag == FOURCC_MOOV) begin
            child_lvl    = 0;
            child_lim[0] = box_end;
            child_ph     = NEST_HEAD;
            child_cnt    = 0;
            child_start  = pos + 1;
        end
    endfunction

    // one byte inside a moov body; returns 1 on a video handler
    function automatic bit moov_child_byte(longint unsigned pos, byte unsigned b);
        bit              again;
        longint unsigned sz, room, off;
        logic [31:0]     tag;
        again = 1;
        while (again) begin
            again = 0;
            if ((child_ph == NEST_SKIP || child_ph == NEST_HDLR) && pos >= child_end) begin
                child_ph = NEST_HEAD; child_cnt = 0; child_start = pos; again = 1;
            end else if ((child_ph == NEST_BROKEN || (child_ph == NEST_HEAD && child_cnt == 0))
                         && pos >= child_lim[child_lvl]) begin
                if (child_lvl > 0) begin
                    child_lvl--;
                    child_ph = NEST_HEAD; child_cnt = 0; child_start = pos; again = 1;
                end else begin
                    child_ph = NEST_OFF;
                    return 0;
                end
            end else if (child_ph == NEST_HEAD && child_cnt == 0
                         && child_lim[child_lvl] - pos < 8) begin
                child_ph = NEST_BROKEN;
            end
        end
        if (child_ph == NEST_HEAD) begin
            child_hdr[child_cnt & 7] = b;
            child_cnt++;
            if (child_cnt == 8) begin
                sz   = {child_hdr[0], child_hdr[1], child_hdr[2], child_hdr[3]};
                room = child_lim[child_lvl] - child_start;
                tag  = {child_hdr[4], child_hdr[5], child_hdr[6], child_hdr[7]};
                if (sz < 8 || sz > room) begin
                    child_ph = NEST_BROKEN;
                    return 0;
                end
                child_end = child_start + sz;
                if ((child_lvl == 0 && tag == FOURCC_TRAK) ||
                    (child_lvl == 1 && tag == FOURCC_MDIA)) begin
                    child_lvl++;
                    child_lim[child_lvl] = child_end;
                    child_ph = NEST_HEAD; child_cnt = 0; child_start = pos + 1;
                end else if (child_lvl == 2 && tag == FOURCC_HDLR) begin
                    child_ph = NEST_HDLR;
                end else begin
                    child_ph = NEST_SKIP;
                end
            end
        end else if (child_ph == NEST_HDLR) begin
            off = pos - child_start;
            if (off >= 16 && off <= 19) begin
                child_hdr[8 + off - 16] = b;
                if (off == 19 && {child_hdr[8], child_hdr[9], child_hdr[10], child_hdr[11]}
                                 == FOURCC_VIDE)
                    return 1;
            end
        end
        return 0;
    endfunction

    function automatic void walk_one(longint unsigned pos, byte unsigned b);
        longint unsigned sz;
        if (walk_ph == WALK_BODY && pos >= box_end) begin
            walk_ph = WALK_HEAD; hdr_cnt = 0; child_ph = NEST_OFF;
        end
        if (walk_ph == WALK_HEAD && hdr_cnt == 0) begin
            box_start = pos;
            if (box_start + 8 > window_limit() || box_count >= BOX_LIMIT) begin
                close_walk();
                return;
            end
        end
        if (walk_ph == WALK_HEAD) begin
            box_hdr[hdr_cnt & 15] = b;
            hdr_cnt++;
            if (hdr_cnt == 8) begin
                for (int i = 4; i < 8; i++)
                    if (!type_char_ok(box_hdr[i])) begin
                        if (box_count == 0) post_verdict(1'b1, REASON_BAD_TYPE, 0);
                        else                post_verdict(1'b0, REASON_NONE, last_end);
                        return;
                    end
                sz = {box_hdr[0], box_hdr[1], box_hdr[2], box_hdr[3]};
                if (sz == 0)      close_walk();
                else if (sz == 1) walk_ph = WALK_EXT;
                else              take_box(pos, sz, 8);
            end
        end else if (walk_ph == WALK_EXT) begin
            box_hdr[hdr_cnt & 15] = b;
            hdr_cnt++;
            if (hdr_cnt == 16) begin
                sz = 0;
                for (int i = 8; i < 16; i++) sz = (sz << 8) | box_hdr[i];
                if (sz > SIZE_MAX) close_walk();
                else               take_box(pos, sz, 16);
            end
        end else if (walk_ph == WALK_BODY && child_ph != NEST_OFF) begin
            if (moov_child_byte(pos, b)) post_verdict(1'b1, REASON_VIDEO, 0);
        end
    endfunction

    function automatic void predict_byte(byte unsigned b, bit eos);
        longint unsigned pos;
        pos = walk_pos & POS_MASK;
        verdict_due = 0;
        if (walk_ph != WALK_DONE) walk_one(pos, b);
        if (!verdict_due && eos && walk_ph != WALK_DONE) close_walk();
        walk_pos = (pos + 1) & POS_MASK;
        if (verdict_due) verdicts_due = {verdicts_due, verdict_now};
        if (eos) restart_walk();
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus a counted long hold-off
    // ------------------------------------------------------------------
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check against the oldest queued verdict
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: verdict %0d reason %0d carve %0d count %0d",
                             m_verdict, m_reject_reason, m_carve_length, m_atom_count);
            end else begin
                want = verdicts_due.pop_front();
                if (m_verdict !== want.verdict || m_reject_reason !== want.reject_reason ||
                    m_carve_length !== want.carve_length ||
                    m_atom_count !== want.atom_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.verdict, want.reject_reason, want.carve_length,
                                 want.atom_count, m_verdict, m_reject_reason,
                                 m_carve_length, m_atom_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    byte unsigned stream_bytes [$];

    function automatic void append_byte(byte unsigned b);
        stream_bytes = {stream_bytes, b};
    endfunction

    // one item; valid is only dropped when an idle gap is taken
    task automatic send_byte(byte unsigned b, bit eos);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_source <= eos;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, eos);
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    // lets every queued verdict drain and the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [WINDOW_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW_LENGTH) win_len = val;
        else if (idx == CFG_AUDIO_ONLY) audio_mode = val[0];
        @(posedge aclk);
    endtask

    task automatic add_be(longint unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) append_byte(8'(v >> (8 * i)));
    endtask

    task automatic add_fill(int n);
        repeat (n) append_byte(8'($urandom_range(255)));
    endtask

    task automatic put_box(int unsigned size, logic [31:0] tag);
        add_be(size, 4);
        add_be(tag, 4);
        if (size > 8) add_fill(size - 8);
    endtask

    function automatic logic [31:0] random_tag();
        logic [31:0] t;
        for (int i = 0; i < 4; i++) t[8*i +: 8] = 8'(8'h61 + $urandom_range(25));
        return t;
    endfunction

    // moov holding one or two traks, each mdia with an optional mdhd and a hdlr
    task automatic put_moov(logic [31:0] handler);
        int unsigned traks, extra, mdhd, hsize, msize, tsize;
        traks = $urandom_range(1, 2);
        extra = $urandom_range(0, 8);
        mdhd  = $urandom_range(0, 1) ? 8 + $urandom_range(0, 12) : 0;
        hsize = 20 + extra;
        msize = 8 + mdhd + hsize;
        tsize = 8 + msize;
        add_be(8 + traks * tsize, 4); add_be(FOURCC_MOOV, 4);
        repeat (traks) begin
            add_be(tsize, 4); add_be(FOURCC_TRAK, 4);
            add_be(msize, 4); add_be(FOURCC_MDIA, 4);
            if (mdhd != 0) put_box(mdhd, FOURCC_MDHD);
            add_be(hsize, 4); add_be(FOURCC_HDLR, 4);
            add_fill(8);
            add_be(handler, 4);
            add_fill(extra);
        end
    endtask

    task automatic build_container();
        int unsigned parts, moov_at;
        stream_bytes.delete();
        if ($urandom_range(9) != 0) put_box(16 + 4 * $urandom_range(0, 4), FOURCC_FTYP);
        parts = $urandom_range(1, 4);
        repeat (parts) begin
            case ($urandom_range(0, 5))
                0, 1: put_box(8 + $urandom_range(0, 40), FOURCC_MDAT);
                2: begin
                    moov_at = stream_bytes.size();
                    case ($urandom_range(0, 2))
                        0: put_moov(FOURCC_VIDE);
                        1: put_moov(FOURCC_SOUN);
                        default: put_moov(random_tag());
                    endcase
                    // occasionally damage a child header
                    if ($urandom_range(4) == 0)
                        stream_bytes[moov_at + $urandom_range(8, 40)] =
                            8'($urandom_range(255));
                end
                3: put_box(8 + $urandom_range(0, 20), random_tag());
                4: begin
                    add_be(1, 4); add_be(FOURCC_MDAT, 4);
                    begin
                        int unsigned body;
                        body = $urandom_range(0, 24);
                        add_be(16 + body, 8);
                        add_fill(body);
                    end
                end
                default: begin
                    add_be(0, 4); add_be(FOURCC_FREE, 4); add_fill($urandom_range(0, 6));
                end
            endcase
        end
        // truncated source or trailing junk now and then
        if ($urandom_range(7) == 0)
            while (stream_bytes.size() > 1 && $urandom_range(3) != 0) void'(stream_bytes.pop_back());
        else if ($urandom_range(7) == 0)
            add_fill($urandom_range(1, 12));
    endtask

    task automatic build_noise();
        stream_bytes.delete();
        if ($urandom_range(1)) begin
            case ($urandom_range(0, 4))
                0: add_be(0, 4);
                1: add_be(1, 4);
                2: add_be($urandom_range(2, 7), 4);
                3: add_be($urandom, 4);
                default: add_be(8 + $urandom_range(0, 30), 4);
            endcase
            if ($urandom_range(1)) add_be(random_tag(), 4);
        end
        add_fill($urandom_range(1, 40));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_plain_walks();
        stream_bytes.delete();                      // ftyp + mdat accepted
        put_box(16, FOURCC_FTYP); put_box(12, FOURCC_MDAT); send_stream();
        stream_bytes.delete();                      // bad first type
        add_be(16, 4); add_be(32'h6162_0163, 4); add_fill(8); send_stream();
        stream_bytes.delete();                      // high type character after a box still counts
        put_box(16, FOURCC_FTYP); put_box(8, FOURCC_MDAT);
        add_be(12, 4); add_be(32'h6D64_61FF, 4); add_fill(4); send_stream();
        stream_bytes.delete();                      // single box only
        put_box(20, FOURCC_FTYP); send_stream();
        stream_bytes.delete();                      // zero size ends walk
        put_box(16, FOURCC_FTYP); put_box(8, FOURCC_MOOV);
        add_be(0, 4); add_be(FOURCC_FREE, 4); send_stream();
        stream_bytes.delete();                      // size below header length
        put_box(16, FOURCC_FTYP); add_be(5, 4); add_be(FOURCC_MDAT, 4); send_stream();
        stream_bytes.delete();                      // large size, valid then under sixteen
        put_box(16, FOURCC_FTYP);
        add_be(1, 4); add_be(FOURCC_MDAT, 4); add_be(20, 8); add_fill(4);
        add_be(1, 4); add_be(FOURCC_FREE, 4); add_be(9, 8); send_stream();
        stream_bytes.delete();                      // large size above the signed range
        put_box(16, FOURCC_FTYP); put_box(8, FOURCC_MDAT);
        add_be(1, 4); add_be(FOURCC_MDAT, 4); add_be(64'hFFFF_FFFF_FFFF_FFFF, 8);
        send_stream();
        stream_bytes.delete();                      // source ends inside a counted body
        put_box(16, FOURCC_FTYP); add_be(100, 4); add_be(FOURCC_MDAT, 4); add_fill(5);
        send_stream();
        stream_bytes.delete();                      // no key box at all
        put_box(12, FOURCC_FREE); put_box(12, FOURCC_FREE); send_stream();
        drain();
    endtask

    task automatic test_window_limits();
        write_reg(CFG_WINDOW_LENGTH, '0);
        build_container(); send_stream();
        drain();
        write_reg(CFG_WINDOW_LENGTH, 36'd30);       // box runs past the window
        stream_bytes.delete();
        put_box(16, FOURCC_FTYP); put_box(20, FOURCC_MDAT); send_stream();
        stream_bytes.delete();                      // header does not fit
        put_box(16, FOURCC_FTYP); put_box(8, FOURCC_MDAT); put_box(8, FOURCC_MDAT);
        send_stream();
        drain();
        write_reg(CFG_WINDOW_LENGTH, {WINDOW_W{1'b1}});
        build_container(); send_stream();
        drain();
        write_reg(CFG_WINDOW_LENGTH, WINDOW_RESET);
    endtask

    task automatic test_audio_handlers();
        write_reg(CFG_AUDIO_ONLY, WINDOW_W'(1));
        stream_bytes.delete();
        put_box(16, FOURCC_FTYP); put_moov(FOURCC_VIDE); put_box(12, FOURCC_MDAT);
        send_stream();
        stream_bytes.delete();
        put_box(16, FOURCC_FTYP); put_moov(FOURCC_SOUN); put_box(12, FOURCC_MDAT);
        send_stream();
        stream_bytes.delete();                      // broken child size
        put_box(16, FOURCC_FTYP); put_moov(FOURCC_VIDE);
        stream_bytes[16 + 11] = 8'h03;
        send_stream();
        drain();
        write_reg(CFG_AUDIO_ONLY, WINDOW_W'(0));
        stream_bytes.delete();
        put_box(16, FOURCC_FTYP); put_moov(FOURCC_VIDE); send_stream();
        drain();
    endtask

    task automatic test_backpressure();
        // receiver held off while short streams keep coming
        hold_left = 400;
        repeat (6) begin
            build_noise();
            send_stream();
        end
        // sender waits for every verdict before carrying on
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        build_container(); send_stream();
        drain();
    endtask

    task automatic test_random_streams();
        int unsigned streams;
        streams = 0;
        // two streams in each idling phase
        while (streams < 8) begin
            if (streams % 2 == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_WINDOW_LENGTH, WINDOW_RESET);
                    1: write_reg(CFG_WINDOW_LENGTH, WINDOW_W'(30 + $urandom_range(0, 200)));
                    2: write_reg(CFG_WINDOW_LENGTH, {WINDOW_W{1'b1}});
                    default: write_reg(CFG_WINDOW_LENGTH,
                                       WINDOW_W'(60 + $urandom_range(0, 60)));
                endcase
                write_reg(CFG_AUDIO_ONLY, WINDOW_W'($urandom_range(1)));
                case ((streams / 2) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                    default: begin send_idle_pct = 17; recv_stall_pct = 17; end
                endcase
            end
            if ($urandom_range(99) < 75) build_container();
            else                         build_noise();
            send_stream();
            streams++;
        end
        drain();
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_data_byte     <= '0;
        s_end_of_source <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_addr        <= '0;
        cfg_data        <= '0;
        win_len    = WINDOW_RESET;
        audio_mode = 0;
        restart_walk();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_walks();
        test_window_limits();
        test_audio_handlers();
        test_backpressure();
        test_random_streams();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #4ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
